// File: hw/rtl/assert_macros.svh
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define CAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies another in the next cycle
`define CAC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/cac_pkg.sv
`timescale 1ns / 1ps

package cac_pkg;

    localparam int RES_W    = 40;
    localparam int SYM_W    = 5;
    localparam int TAIL_LEN = 8;

    localparam logic [RES_W-1:0] PREFIX_START          = 40'd1;
    localparam logic [RES_W-1:0] FINAL_XOR             = 40'd1;
    localparam logic [RES_W-1:0] DEFAULT_RESIDUE_RESET = 40'd32;

    localparam logic [RES_W-1:0] GEN [5] = '{
        40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
        40'hae2eabe2a8, 40'h1e4f43e470
    };

    // "qpzry9x8gf2tvdw0s3jn54khce6mua7l"
    localparam logic [7:0] CHARSET [32] = '{
        8'h71, 8'h70, 8'h7A, 8'h72, 8'h79, 8'h39, 8'h78, 8'h38,
        8'h67, 8'h66, 8'h32, 8'h74, 8'h76, 8'h64, 8'h77, 8'h30,
        8'h73, 8'h33, 8'h6A, 8'h6E, 8'h35, 8'h34, 8'h6B, 8'h68,
        8'h63, 8'h65, 8'h36, 8'h6D, 8'h75, 8'h61, 8'h37, 8'h6C
    };

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHAR_DIG_0  = 8'h30;
    localparam logic [7:0] CHAR_DIG_9  = 8'h39;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    localparam logic REG_DIRECTION       = 1'b0;
    localparam logic REG_DEFAULT_RESIDUE = 1'b1;

    localparam logic DIR_CREATE = 1'b0;
    localparam logic DIR_VERIFY = 1'b1;

    localparam logic MODE_PREFIX = 1'b0;
    localparam logic MODE_SYMBOL = 1'b1;

    localparam logic [3:0] MIN_DATA = 4'd8;

    typedef enum logic [1:0] {
        ST_PENDING   = 2'd0,
        ST_VALID     = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_MISMATCH  = 2'd3
    } status_t;

    // results of one accepted item: up to two leading characters, then the
    // optional eight-letter checksum tail
    typedef struct packed {
        logic [1:0]       n_pre;
        logic [7:0]       pre0_char;
        status_t          pre0_status;
        logic             pre0_last;
        logic [7:0]       pre1_char;
        logic             tail;
        logic [RES_W-1:0] residue;
    } burst_t;

    function automatic logic [RES_W-1:0] poly_step(input logic [RES_W-1:0] r,
                                                   input logic [SYM_W-1:0] d);
        logic [SYM_W-1:0] top;
        logic [RES_W-1:0] acc;
        top = r[RES_W-1 -: SYM_W];
        acc = {r[RES_W-SYM_W-1:0], d};
        for (int b = 0; b < SYM_W; b++)
        begin
            if (top[b])
            begin
                acc = acc ^ GEN[b];
            end
        end
        return acc;
    endfunction

    // eight zero symbols then the final xor
    function automatic logic [RES_W-1:0] poly_tail(input logic [RES_W-1:0] r);
        logic [RES_W-1:0] acc;
        acc = r;
        for (int i = 0; i < TAIL_LEN; i++)
        begin
            acc = poly_step(acc, '0);
        end
        return acc ^ FINAL_XOR;
    endfunction

    // {hit, symbol} for a character, case folded
    function automatic logic [SYM_W:0] char_to_sym(input logic [7:0] c);
        logic [7:0]       lc;
        logic             hit;
        logic [SYM_W-1:0] idx;
        lc  = c | CASE_BIT;
        hit = 1'b0;
        idx = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (CHARSET[i] == lc)
            begin
                hit = 1'b1;
                idx = SYM_W'(i);
            end
        end
        return {hit, idx};
    endfunction

endpackage

// File: hw/rtl/cac_in_if.sv
`timescale 1ns / 1ps

interface cac_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic [4:0] symbol_in;
    logic       mode;
    logic       last;

    modport source (output valid, char_in, symbol_in, mode, last, input ready);
    modport sink   (input valid, char_in, symbol_in, mode, last, output ready);
endinterface

// File: hw/rtl/cac_out_if.sv
`timescale 1ns / 1ps

interface cac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic [1:0] status;
    logic       last_out;

    modport source (output valid, char_out, status, last_out, input ready);
    modport sink   (input valid, char_out, status, last_out, output ready);
endinterface

// File: hw/rtl/cac_emitter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cac_emitter
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             burst_load,
    input  cac_pkg::burst_t  burst_in,
    output logic             burst_free,
    cac_out_if.source        results
);

    logic              slot_valid_reg, slot_valid_next;
    cac_pkg::burst_t   burst_reg, burst_next;
    logic [3:0]        idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    cac_pkg::status_t  out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic [3:0]                  total;
    logic                        at_end;
    logic                        advance;
    logic [2:0]                  tail_idx;
    logic [cac_pkg::RES_W-1:0]   cksum;
    logic [cac_pkg::RES_W-1:0]   cksum_sh;
    logic [7:0]                  entry_char;
    cac_pkg::status_t            entry_status;
    logic                        entry_last;

    assign total    = {2'b00, burst_reg.n_pre} + (burst_reg.tail ? 4'(cac_pkg::TAIL_LEN) : 4'd0);
    assign at_end   = (idx_reg == total - 4'd1);
    assign advance  = slot_valid_reg && (!out_valid_reg || results.ready);
    assign burst_free = !slot_valid_reg || (advance && at_end);

    assign tail_idx = 3'(idx_reg - {2'b00, burst_reg.n_pre});
    assign cksum    = cac_pkg::poly_tail(burst_reg.residue);
    // first letter carries the top five bits
    assign cksum_sh = cksum >> (6'd5 * {3'b000, 3'd7 - tail_idx});

    always_comb
    begin
        if (idx_reg < {2'b00, burst_reg.n_pre})
        begin
            if (idx_reg == 4'd0)
            begin
                entry_char   = burst_reg.pre0_char;
                entry_status = burst_reg.pre0_status;
                entry_last   = burst_reg.pre0_last;
            end
            else
            begin
                entry_char   = burst_reg.pre1_char;
                entry_status = cac_pkg::ST_PENDING;
                entry_last   = 1'b0;
            end
        end
        else
        begin
            entry_char   = cac_pkg::CHARSET[cksum_sh[cac_pkg::SYM_W-1:0]];
            entry_status = (tail_idx == 3'd7) ? cac_pkg::ST_VALID : cac_pkg::ST_PENDING;
            entry_last   = (tail_idx == 3'd7);
        end
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        burst_next      = burst_reg;
        idx_next        = idx_reg;
        if (burst_load)
        begin
            slot_valid_next = 1'b1;
            burst_next      = burst_in;
            idx_next        = 4'd0;
        end
        else if (advance && at_end)
        begin
            slot_valid_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (advance)
        begin
            out_valid_next  = 1'b1;
            out_char_next   = entry_char;
            out_status_next = entry_status;
            out_last_next   = entry_last;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            idx_reg        <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_reg      <= burst_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign results.valid    = out_valid_reg;
    assign results.char_out = out_char_reg;
    assign results.status   = out_status_reg;
    assign results.last_out = out_last_reg;

    `CAC_ASSERT(a_idx_in_range, slot_valid_reg |-> (idx_reg < total), "burst index past end")
    `CAC_ASSERT(a_load_when_free, burst_load |-> burst_free, "burst loaded over a busy slot")
    `CAC_ASSERT(a_load_nonempty, burst_load |-> ((burst_in.n_pre != 2'd0) || burst_in.tail), "empty burst loaded")
    `CAC_ASSERT_NEXT(a_load_starts, burst_load, slot_valid_reg && (idx_reg == 4'd0), "burst did not start at entry zero")
    `CAC_ASSERT(a_last_has_verdict, (out_valid_reg && out_last_reg) |-> (out_status_reg != cac_pkg::ST_PENDING), "final result without verdict")

endmodule

// File: hw/rtl/cashaddr_checksum_codec.sv
`timescale 1ns / 1ps
// cashaddr checksum codec: streams address text through the 40-bit polymod.
// items (sink): one character or payload symbol per transfer, last marks
//   the final item of an address. results (source): one character/status
//   per transfer. cfg_we/cfg_index/cfg_data write direction (0) and the
//   default residue (1); write only while the block is idle.
// create: prefix characters are echoed, the first symbol is preceded by
//   a colon, each symbol gives its charset letter; a last item adds eight
//   checksum letters, the final one with status 1 and last_out set.
// verify: one result per character, status pending until the last one,
//   which carries valid, malformed or mismatch.
// an item's first result goes through the burst register, then the result
//   register. throughput: one item per cycle when each item gives one result
//   and no result is stalled; an item giving several results holds the input
//   until its last result is registered (the create finale gives up to ten).
// the result register decouples the sides: a stalled final result does not
//   block the next item; results wait unchanged while ready is low.
// reset: per-address state clears, direction create, default residue 32;
//   no clearing pass, items are taken right away.
module cashaddr_checksum_codec
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [39:0] cfg_data,
    cac_in_if.sink      items,
    cac_out_if.source   results
);

    logic        direction_reg;
    logic [39:0] default_residue_reg;

    logic [39:0] prefix_residue_reg, prefix_residue_next;
    logic [39:0] data_residue_reg, data_residue_next;
    logic        seen_lower_reg, seen_lower_next;
    logic        seen_upper_reg, seen_upper_next;
    logic        seen_digit_reg, seen_digit_next;
    logic        seen_separator_reg, seen_separator_next;
    logic        at_first_char_reg, at_first_char_next;
    logic        default_path_bad_reg, default_path_bad_next;
    logic        format_error_reg, format_error_next;
    logic        payload_started_reg, payload_started_next;
    logic [3:0]  data_count_reg, data_count_next;

    cac_pkg::burst_t burst;
    logic            burst_free;
    logic            burst_load;
    logic            in_fire;

    logic [39:0] base_residue;
    logic [5:0]  lookup;
    logic        is_lower, is_upper, is_digit;
    logic [39:0] open_residue;

    assign items.ready = burst_free;
    assign in_fire     = items.valid && burst_free;
    assign burst_load  = in_fire && ((burst.n_pre != 2'd0) || burst.tail);

    assign base_residue = at_first_char_reg ? default_residue_reg : data_residue_reg;
    assign lookup       = cac_pkg::char_to_sym(items.char_in);
    assign is_lower = (items.char_in >= cac_pkg::CHAR_LOW_A) && (items.char_in <= cac_pkg::CHAR_LOW_Z);
    assign is_upper = (items.char_in >= cac_pkg::CHAR_UP_A) && (items.char_in <= cac_pkg::CHAR_UP_Z);
    assign is_digit = (items.char_in >= cac_pkg::CHAR_DIG_0) && (items.char_in <= cac_pkg::CHAR_DIG_9);
    assign open_residue = cac_pkg::poly_step(prefix_residue_reg, '0);

    always_comb
    begin
        prefix_residue_next   = prefix_residue_reg;
        data_residue_next     = data_residue_reg;
        seen_lower_next       = seen_lower_reg;
        seen_upper_next       = seen_upper_reg;
        seen_digit_next       = seen_digit_reg;
        seen_separator_next   = seen_separator_reg;
        at_first_char_next    = at_first_char_reg;
        default_path_bad_next = default_path_bad_reg;
        format_error_next     = format_error_reg;
        payload_started_next  = payload_started_reg;
        data_count_next       = data_count_reg;
        burst             = '0;
        burst.pre0_status = cac_pkg::ST_PENDING;

        if (in_fire)
        begin
            at_first_char_next = 1'b0;
            if (direction_reg == cac_pkg::DIR_CREATE)
            begin
                if (items.mode == cac_pkg::MODE_PREFIX)
                begin
                    // prefix characters after the payload are dropped
                    if (!payload_started_reg)
                    begin
                        prefix_residue_next = cac_pkg::poly_step(prefix_residue_reg,
                                                                 items.char_in[4:0]);
                        burst.n_pre     = 2'd1;
                        burst.pre0_char = items.char_in;
                        if (items.last)
                        begin
                            burst.n_pre     = 2'd2;
                            burst.pre1_char = cac_pkg::CHAR_COLON;
                            data_residue_next = cac_pkg::poly_step(prefix_residue_next, '0);
                        end
                    end
                end
                else if (!payload_started_reg)
                begin
                    payload_started_next = 1'b1;
                    data_residue_next = cac_pkg::poly_step(open_residue, items.symbol_in);
                    burst.n_pre     = 2'd2;
                    burst.pre0_char = cac_pkg::CHAR_COLON;
                    burst.pre1_char = cac_pkg::CHARSET[items.symbol_in];
                end
                else
                begin
                    data_residue_next = cac_pkg::poly_step(data_residue_reg, items.symbol_in);
                    burst.n_pre     = 2'd1;
                    burst.pre0_char = cac_pkg::CHARSET[items.symbol_in];
                end
                burst.tail    = items.last;
                burst.residue = data_residue_next;
            end
            else
            begin
                data_residue_next = base_residue;
                if (items.char_in == cac_pkg::CHAR_COLON)
                begin
                    if (seen_digit_reg || at_first_char_reg || seen_separator_reg)
                    begin
                        format_error_next = 1'b1;
                    end
                    else
                    begin
                        seen_separator_next = 1'b1;
                        data_residue_next   = open_residue;
                        data_count_next     = 4'd0;
                    end
                end
                else if (is_lower || is_upper || is_digit)
                begin
                    if (is_lower)
                    begin
                        seen_lower_next = 1'b1;
                    end
                    else if (is_upper)
                    begin
                        seen_upper_next = 1'b1;
                    end
                    else
                    begin
                        seen_digit_next = 1'b1;
                    end
                    if (!seen_separator_reg)
                    begin
                        prefix_residue_next = cac_pkg::poly_step(prefix_residue_reg,
                                                                 items.char_in[4:0]);
                    end
                    if (!lookup[5])
                    begin
                        if (seen_separator_reg)
                        begin
                            format_error_next = 1'b1;
                        end
                        else
                        begin
                            default_path_bad_next = 1'b1;
                        end
                    end
                    else
                    begin
                        data_residue_next = cac_pkg::poly_step(base_residue, lookup[4:0]);
                        if (data_count_reg < cac_pkg::MIN_DATA)
                        begin
                            data_count_next = data_count_reg + 4'd1;
                        end
                    end
                end
                else
                begin
                    format_error_next = 1'b1;
                end

                burst.n_pre     = 2'd1;
                burst.pre0_char = 8'd0;
                burst.pre0_last = items.last;
                if (items.last)
                begin
                    if (format_error_next || (seen_upper_next && seen_lower_next) ||
                        (!seen_separator_next && default_path_bad_next) ||
                        (data_count_next < cac_pkg::MIN_DATA))
                    begin
                        burst.pre0_status = cac_pkg::ST_MALFORMED;
                    end
                    else if (data_residue_next == cac_pkg::FINAL_XOR)
                    begin
                        burst.pre0_status = cac_pkg::ST_VALID;
                    end
                    else
                    begin
                        burst.pre0_status = cac_pkg::ST_MISMATCH;
                    end
                end
            end

            // start of the next address
            if (items.last)
            begin
                prefix_residue_next   = cac_pkg::PREFIX_START;
                data_residue_next     = default_residue_reg;
                seen_lower_next       = 1'b0;
                seen_upper_next       = 1'b0;
                seen_digit_next       = 1'b0;
                seen_separator_next   = 1'b0;
                at_first_char_next    = 1'b1;
                default_path_bad_next = 1'b0;
                format_error_next     = 1'b0;
                payload_started_next  = 1'b0;
                data_count_next       = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg       <= cac_pkg::DIR_CREATE;
            default_residue_reg <= cac_pkg::DEFAULT_RESIDUE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cac_pkg::REG_DIRECTION:       direction_reg       <= cfg_data[0];
                cac_pkg::REG_DEFAULT_RESIDUE: default_residue_reg <= cfg_data;
                default:                      direction_reg       <= direction_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_residue_reg   <= cac_pkg::PREFIX_START;
            data_residue_reg     <= cac_pkg::DEFAULT_RESIDUE_RESET;
            seen_lower_reg       <= 1'b0;
            seen_upper_reg       <= 1'b0;
            seen_digit_reg       <= 1'b0;
            seen_separator_reg   <= 1'b0;
            at_first_char_reg    <= 1'b1;
            default_path_bad_reg <= 1'b0;
            format_error_reg     <= 1'b0;
            payload_started_reg  <= 1'b0;
            data_count_reg       <= 4'd0;
        end
        else
        begin
            prefix_residue_reg   <= prefix_residue_next;
            data_residue_reg     <= data_residue_next;
            seen_lower_reg       <= seen_lower_next;
            seen_upper_reg       <= seen_upper_next;
            seen_digit_reg       <= seen_digit_next;
            seen_separator_reg   <= seen_separator_next;
            at_first_char_reg    <= at_first_char_next;
            default_path_bad_reg <= default_path_bad_next;
            format_error_reg     <= format_error_next;
            payload_started_reg  <= payload_started_next;
            data_count_reg       <= data_count_next;
        end
    end

    cac_emitter u_emitter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst_load (burst_load),
        .burst_in   (burst),
        .burst_free (burst_free),
        .results    (results)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 45;

    typedef struct packed {
        logic [7:0] ch;
        logic [4:0] sym;
        logic       md;
        logic       lst;
    } item_t;

    typedef struct packed {
        logic [7:0]       ch;
        cac_pkg::status_t st;
        logic             lst;
    } result_t;

    // one directed transfer; typed marks a first result written out by hand
    typedef struct packed {
        logic             dir;
        logic [7:0]       ch;
        logic [4:0]       sym;
        logic             md;
        logic             lst;
        logic             typed;
        logic [7:0]       e_ch;
        cac_pkg::status_t e_st;
        logic             e_lst;
    } row_t;

    typedef enum int {
        FLIP_LETTER, RANDOM_BYTE, CASE_SWAP, STRAY_COLON, TRUNCATE, DIGIT_FIRST, DROP_COLON
    } defect_t;

    localparam row_t PLAN [21] = '{
        // create: prefix echo with byte extremes, then the colon and a symbol letter
        '{cac_pkg::DIR_CREATE, 8'h61, 5'd0, cac_pkg::MODE_PREFIX, 1'b0,
          1'b1, 8'h61, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_CREATE, 8'hFF, 5'd0, cac_pkg::MODE_PREFIX, 1'b0,
          1'b1, 8'hFF, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_CREATE, 8'h00, 5'd0, cac_pkg::MODE_PREFIX, 1'b0,
          1'b1, 8'h00, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_CREATE, 8'h00, 5'd0, cac_pkg::MODE_SYMBOL, 1'b0,
          1'b1, cac_pkg::CHAR_COLON, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_CREATE, 8'h00, 5'd31, cac_pkg::MODE_SYMBOL, 1'b0,
          1'b1, cac_pkg::CHARSET[31], cac_pkg::ST_PENDING, 1'b0},
        // prefix character after payload is dropped
        '{cac_pkg::DIR_CREATE, 8'h78, 5'd0, cac_pkg::MODE_PREFIX, 1'b0,
          1'b0, 8'h00, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_CREATE, 8'h00, 5'd5, cac_pkg::MODE_SYMBOL, 1'b1,
          1'b1, cac_pkg::CHARSET[5], cac_pkg::ST_PENDING, 1'b0},
        // empty prefix
        '{cac_pkg::DIR_CREATE, 8'hFF, 5'd31, cac_pkg::MODE_SYMBOL, 1'b0,
          1'b1, cac_pkg::CHAR_COLON, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_CREATE, 8'h00, 5'd0, cac_pkg::MODE_SYMBOL, 1'b1,
          1'b0, 8'h00, cac_pkg::ST_PENDING, 1'b0},
        // no payload at all
        '{cac_pkg::DIR_CREATE, 8'h7A, 5'd0, cac_pkg::MODE_PREFIX, 1'b1,
          1'b1, 8'h7A, cac_pkg::ST_PENDING, 1'b0},
        // ignored last prefix character still closes the address
        '{cac_pkg::DIR_CREATE, 8'h00, 5'd3, cac_pkg::MODE_SYMBOL, 1'b0,
          1'b1, cac_pkg::CHAR_COLON, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_CREATE, 8'h71, 5'd0, cac_pkg::MODE_PREFIX, 1'b1,
          1'b0, 8'h00, cac_pkg::ST_PENDING, 1'b0},
        // address begun in create, finished in verify
        '{cac_pkg::DIR_CREATE, 8'h70, 5'd0, cac_pkg::MODE_PREFIX, 1'b0,
          1'b1, 8'h70, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_VERIFY, 8'h31, 5'd0, cac_pkg::MODE_PREFIX, 1'b0,
          1'b1, 8'h00, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_VERIFY, cac_pkg::CHAR_COLON, 5'd31, cac_pkg::MODE_SYMBOL, 1'b0,
          1'b1, 8'h00, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_VERIFY, 8'h71, 5'd0, cac_pkg::MODE_PREFIX, 1'b1,
          1'b1, 8'h00, cac_pkg::ST_MALFORMED, 1'b1},
        // colon first, illegal bytes
        '{cac_pkg::DIR_VERIFY, cac_pkg::CHAR_COLON, 5'd0, cac_pkg::MODE_PREFIX, 1'b1,
          1'b1, 8'h00, cac_pkg::ST_MALFORMED, 1'b1},
        '{cac_pkg::DIR_VERIFY, 8'h00, 5'd0, cac_pkg::MODE_PREFIX, 1'b1,
          1'b1, 8'h00, cac_pkg::ST_MALFORMED, 1'b1},
        '{cac_pkg::DIR_VERIFY, 8'hFF, 5'd31, cac_pkg::MODE_SYMBOL, 1'b1,
          1'b1, 8'h00, cac_pkg::ST_MALFORMED, 1'b1},
        // mixed case
        '{cac_pkg::DIR_VERIFY, 8'h41, 5'd0, cac_pkg::MODE_PREFIX, 1'b0,
          1'b1, 8'h00, cac_pkg::ST_PENDING, 1'b0},
        '{cac_pkg::DIR_VERIFY, 8'h62, 5'd0, cac_pkg::MODE_PREFIX, 1'b1,
          1'b1, 8'h00, cac_pkg::ST_MALFORMED, 1'b1}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [39:0] cfg_data;

    cac_in_if  item_bus();
    cac_out_if result_bus();

    cashaddr_checksum_codec i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_bus),
        .results   (result_bus)
    );

    // codec state as the block should hold it
    logic        cur_dir;
    logic [39:0] cur_default;
    logic [39:0] pfx_res;
    logic [39:0] dat_res;
    logic        saw_lower, saw_upper, saw_digit, saw_colon;
    logic        first_char, dflt_bad, fmt_bad, payload_open;
    logic [3:0]  n_data;
    int          sym_of_char [256];

    result_t due_outputs[$];
    result_t item_outputs[$];

    int send_idle_pct = 38;
    int recv_idle_pct = 54;
    int mismatch_count = 0;
    int items_sent = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [39:0] polymod_step(input logic [39:0] r, input logic [4:0] d);
        logic [39:0] acc;
        acc = {r[34:0], d};
        for (int b = 0; b < 5; b++)
        begin
            if (r[35 + b])
            begin
                acc = acc ^ cac_pkg::GEN[b];
            end
        end
        return acc;
    endfunction

    task automatic emit(input logic [7:0] ch, input cac_pkg::status_t st, input logic lst);
        result_t r;
        r.ch = ch;
        r.st = st;
        r.lst = lst;
        item_outputs = {item_outputs, r};
    endtask

    task automatic new_address();
        pfx_res = cac_pkg::PREFIX_START;
        dat_res = cur_default;
        saw_lower = 1'b0;
        saw_upper = 1'b0;
        saw_digit = 1'b0;
        saw_colon = 1'b0;
        first_char = 1'b1;
        dflt_bad = 1'b0;
        fmt_bad = 1'b0;
        n_data = '0;
        payload_open = 1'b0;
    endtask

    task automatic open_payload();
        if (!payload_open)
        begin
            payload_open = 1'b1;
            dat_res = polymod_step(pfx_res, '0);
            emit(cac_pkg::CHAR_COLON, cac_pkg::ST_PENDING, 1'b0);
        end
    endtask

    task automatic checksum_letters();
        logic [39:0] r;
        r = dat_res;
        for (int i = 0; i < 8; i++)
        begin
            r = polymod_step(r, '0);
        end
        r = r ^ cac_pkg::FINAL_XOR;
        for (int i = 0; i < 8; i++)
        begin
            emit(cac_pkg::CHARSET[r[5 * (7 - i) +: 5]],
                 (i == 7) ? cac_pkg::ST_VALID : cac_pkg::ST_PENDING, i == 7);
        end
    endtask

    // fills item_outputs with what one accepted item must produce
    task automatic predict_codec(input item_t it);
        cac_pkg::status_t st;
        item_outputs.delete();
        if (cur_dir == cac_pkg::DIR_CREATE)
        begin
            first_char = 1'b0;
            if (it.md == cac_pkg::MODE_PREFIX)
            begin
                if (!payload_open)
                begin
                    pfx_res = polymod_step(pfx_res, it.ch[4:0]);
                    emit(it.ch, cac_pkg::ST_PENDING, 1'b0);
                end
            end
            else
            begin
                open_payload();
                dat_res = polymod_step(dat_res, it.sym);
                emit(cac_pkg::CHARSET[it.sym], cac_pkg::ST_PENDING, 1'b0);
            end
            if (it.lst)
            begin
                open_payload();
                checksum_letters();
                new_address();
            end
        end
        else
        begin
            if (first_char)
            begin
                dat_res = cur_default;
            end
            if (it.ch == cac_pkg::CHAR_COLON)
            begin
                if (saw_digit || first_char || saw_colon)
                begin
                    fmt_bad = 1'b1;
                end
                else
                begin
                    saw_colon = 1'b1;
                    dat_res = polymod_step(pfx_res, '0);
                    n_data = '0;
                end
            end
            else if ((it.ch >= cac_pkg::CHAR_LOW_A && it.ch <= cac_pkg::CHAR_LOW_Z) ||
                     (it.ch >= cac_pkg::CHAR_UP_A && it.ch <= cac_pkg::CHAR_UP_Z) ||
                     (it.ch >= cac_pkg::CHAR_DIG_0 && it.ch <= cac_pkg::CHAR_DIG_9))
            begin
                if (it.ch >= cac_pkg::CHAR_LOW_A && it.ch <= cac_pkg::CHAR_LOW_Z)
                begin
                    saw_lower = 1'b1;
                end
                else if (it.ch >= cac_pkg::CHAR_UP_A && it.ch <= cac_pkg::CHAR_UP_Z)
                begin
                    saw_upper = 1'b1;
                end
                else
                begin
                    saw_digit = 1'b1;
                end
                if (!saw_colon)
                begin
                    pfx_res = polymod_step(pfx_res, it.ch[4:0]);
                end
                if (sym_of_char[it.ch] < 0)
                begin
                    if (saw_colon)
                    begin
                        fmt_bad = 1'b1;
                    end
                    else
                    begin
                        dflt_bad = 1'b1;
                    end
                end
                else
                begin
                    dat_res = polymod_step(dat_res, 5'(sym_of_char[it.ch]));
                    if (n_data < cac_pkg::MIN_DATA)
                    begin
                        n_data = n_data + 4'd1;
                    end
                end
            end
            else
            begin
                fmt_bad = 1'b1;
            end
            first_char = 1'b0;
            st = cac_pkg::ST_PENDING;
            if (it.lst)
            begin
                if (fmt_bad || (saw_upper && saw_lower) || (!saw_colon && dflt_bad) ||
                    n_data < cac_pkg::MIN_DATA)
                begin
                    st = cac_pkg::ST_MALFORMED;
                end
                else if (dat_res == 40'd1)
                begin
                    st = cac_pkg::ST_VALID;
                end
                else
                begin
                    st = cac_pkg::ST_MISMATCH;
                end
            end
            emit(8'h00, st, it.lst);
            if (it.lst)
            begin
                new_address();
            end
        end
    endtask

    task automatic push_item(input item_t it, input logic typed, input result_t typed_first);
        logic taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_bus.valid     <= 1'b1;
        item_bus.char_in   <= it.ch;
        item_bus.symbol_in <= it.sym;
        item_bus.mode      <= it.md;
        item_bus.last      <= it.lst;
        // ready is settled between edges, so look at it before the edge
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = item_bus.ready;
            @(posedge clk);
        end
        predict_codec(it);
        if (typed)
        begin
            item_outputs[0] = typed_first;
        end
        if (item_outputs.size() != 0)
        begin
            items_sent++;
        end
        due_outputs = {due_outputs, item_outputs};
    endtask

    // wait for the block to go quiet; a dropped item gives no result to wait on
    task automatic drain_outputs();
        item_bus.valid <= 1'b0;
        while (due_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [39:0] val);
        drain_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == cac_pkg::REG_DIRECTION)
        begin
            cur_dir = val[0];
        end
        else
        begin
            cur_default = val;
        end
    endtask

    task automatic send_create_address();
        item_t batch[$];
        item_t it;
        int    plen;
        int    nsym;
        plen = $urandom_range(3);
        nsym = $urandom_range(5);
        for (int i = 0; i < plen; i++)
        begin
            it.md  = cac_pkg::MODE_PREFIX;
            it.ch  = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                              : cac_pkg::CHAR_LOW_A + 8'($urandom_range(25));
            it.sym = 5'($urandom_range(31));
            it.lst = 1'b0;
            batch = {batch, it};
        end
        for (int i = 0; i < nsym; i++)
        begin
            it.md  = cac_pkg::MODE_SYMBOL;
            it.ch  = 8'($urandom_range(255));
            it.sym = 5'($urandom_range(31));
            it.lst = 1'b0;
            batch = {batch, it};
        end
        // a trailing prefix character, dropped once payload has begun
        if (batch.size() == 0 || $urandom_range(3) == 0)
        begin
            it.md  = cac_pkg::MODE_PREFIX;
            it.ch  = 8'($urandom_range(255));
            it.sym = 5'($urandom_range(31));
            it.lst = 1'b0;
            batch = {batch, it};
        end
        batch[batch.size() - 1].lst = 1'b1;
        foreach (batch[i])
        begin
            push_item(batch[i], 1'b0, '0);
        end
    endtask

    task automatic send_verify_address(input logic noise);
        logic [7:0]  text[$];
        logic [39:0] r;
        logic [7:0]  ch;
        logic [4:0]  s;
        item_t       it;
        int          plen;
        int          nsym;
        int          pos;
        logic        upper;
        logic        via_default;
        if (noise)
        begin
            repeat ($urandom_range(6, 1)) text = {text, 8'($urandom_range(255))};
        end
        else
        begin
            upper = ($urandom_range(3) == 0);
            via_default = ($urandom_range(4) == 0);
            plen = $urandom_range(4, 1);
            r = cac_pkg::PREFIX_START;
            for (int i = 0; i < plen; i++)
            begin
                ch = cac_pkg::CHAR_LOW_A + 8'($urandom_range(25));
                r = polymod_step(r, ch[4:0]);
                if (!via_default)
                begin
                    text = {text, ch};
                end
            end
            r = polymod_step(r, '0);
            // without a colon the block must start from the preloaded residue
            if (via_default)
            begin
                write_register(cac_pkg::REG_DEFAULT_RESIDUE, r);
            end
            else
            begin
                text = {text, cac_pkg::CHAR_COLON};
            end
            nsym = $urandom_range(5);
            for (int i = 0; i < nsym; i++)
            begin
                s = 5'($urandom_range(31));
                r = polymod_step(r, s);
                text = {text, cac_pkg::CHARSET[s]};
            end
            for (int i = 0; i < 8; i++)
            begin
                r = polymod_step(r, '0);
            end
            r = r ^ cac_pkg::FINAL_XOR;
            for (int i = 0; i < 8; i++)
            begin
                text = {text, cac_pkg::CHARSET[r[5 * (7 - i) +: 5]]};
            end
            if (upper)
            begin
                foreach (text[i])
                begin
                    if (text[i] >= cac_pkg::CHAR_LOW_A && text[i] <= cac_pkg::CHAR_LOW_Z)
                    begin
                        text[i] = text[i] ^ cac_pkg::CASE_BIT;
                    end
                end
            end
            if ($urandom_range(9) < 3)
            begin
                pos = $urandom_range(text.size() - 1);
                case (defect_t'($urandom_range(6)))
                    FLIP_LETTER: text[pos] = cac_pkg::CHARSET[$urandom_range(31)];
                    RANDOM_BYTE: text[pos] = 8'($urandom_range(255));
                    CASE_SWAP:   text[pos] = text[pos] ^ cac_pkg::CASE_BIT;
                    STRAY_COLON: text[pos] = cac_pkg::CHAR_COLON;
                    TRUNCATE:
                    begin
                        repeat ($urandom_range(8, 1))
                        begin
                            if (text.size() > 1)
                            begin
                                void'(text.pop_back());
                            end
                        end
                    end
                    DIGIT_FIRST: text[0] = cac_pkg::CHAR_DIG_0 + 8'($urandom_range(9));
                    default:
                    begin
                        if (!via_default)
                        begin
                            text.delete(plen);
                        end
                    end
                endcase
            end
        end
        foreach (text[i])
        begin
            it.ch  = text[i];
            it.sym = 5'($urandom_range(31));
            it.md  = 1'($urandom_range(1));
            it.lst = (i == text.size() - 1);
            push_item(it, 1'b0, '0);
        end
    endtask

    task automatic check_result(input logic [7:0] got_ch, input logic [1:0] got_st,
                                input logic got_lst);
        result_t want;
        if (due_outputs.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t: unexpected transfer: char %h status %0d last %0d", $time,
                         got_ch, got_st, got_lst);
            end
        end
        else
        begin
            want = due_outputs.pop_front();
            if (got_ch !== want.ch || got_st !== want.st || got_lst !== want.lst)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: expected char %h status %0d last %0d, got %h %0d %0d",
                             $time, want.ch, want.st, want.lst, got_ch, got_st, got_lst);
                end
            end
        end
    endtask

    // result side: sample between edges, check each transfer, then stall at random
    initial
    begin
        logic       take;
        logic [7:0] got_ch;
        logic [1:0] got_st;
        logic       got_lst;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            take    = rst_n && result_bus.valid && result_bus.ready;
            got_ch  = result_bus.char_out;
            got_st  = result_bus.status;
            got_lst = result_bus.last_out;
            @(posedge clk);
            if (take)
            begin
                check_result(got_ch, got_st, got_lst);
            end
            result_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL cashaddr_checksum_codec");
        $finish;
    end

    initial
    begin
        item_t   it;
        result_t first;
        int      phase_start;
        int      pick;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= cac_pkg::REG_DIRECTION;
        cfg_data           <= '0;
        item_bus.valid     <= 1'b0;
        item_bus.char_in   <= '0;
        item_bus.symbol_in <= '0;
        item_bus.mode      <= cac_pkg::MODE_PREFIX;
        item_bus.last      <= 1'b0;
        for (int c = 0; c < 256; c++)
        begin
            sym_of_char[c] = -1;
        end
        for (int i = 0; i < 32; i++)
        begin
            sym_of_char[cac_pkg::CHARSET[i]] = i;
            if (cac_pkg::CHARSET[i] >= cac_pkg::CHAR_LOW_A &&
                cac_pkg::CHARSET[i] <= cac_pkg::CHAR_LOW_Z)
            begin
                sym_of_char[cac_pkg::CHARSET[i] ^ cac_pkg::CASE_BIT] = i;
            end
        end
        cur_dir = cac_pkg::DIR_CREATE;
        cur_default = cac_pkg::DEFAULT_RESIDUE_RESET;
        new_address();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(cac_pkg::REG_DIRECTION, cac_pkg::DIR_CREATE);
        for (int i = 0; i < $size(PLAN); i++)
        begin
            if (PLAN[i].dir != cur_dir)
            begin
                write_register(cac_pkg::REG_DIRECTION, PLAN[i].dir);
            end
            it.ch  = PLAN[i].ch;
            it.sym = PLAN[i].sym;
            it.md  = PLAN[i].md;
            it.lst = PLAN[i].lst;
            first.ch  = PLAN[i].e_ch;
            first.st  = PLAN[i].e_st;
            first.lst = PLAN[i].e_lst;
            push_item(it, PLAN[i].typed, first);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 38 : 0;
            phase_start = items_sent;
            if (ph == 0)
            begin
                write_register(cac_pkg::REG_DEFAULT_RESIDUE, '0);
            end
            else if (ph == 1)
            begin
                write_register(cac_pkg::REG_DEFAULT_RESIDUE, '1);
            end
            else
            begin
                write_register(cac_pkg::REG_DEFAULT_RESIDUE, {8'($urandom), 32'($urandom)});
            end
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(9);
                if (pick < 4)
                begin
                    if (cur_dir != cac_pkg::DIR_CREATE)
                    begin
                        write_register(cac_pkg::REG_DIRECTION, cac_pkg::DIR_CREATE);
                    end
                    send_create_address();
                end
                else
                begin
                    if (cur_dir != cac_pkg::DIR_VERIFY)
                    begin
                        write_register(cac_pkg::REG_DIRECTION, cac_pkg::DIR_VERIFY);
                    end
                    send_verify_address(pick == 9);
                end
            end
        end

        item_bus.valid <= 1'b0;
        while (due_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS cashaddr_checksum_codec");
        end
        else
        begin
            $display("FAIL cashaddr_checksum_codec");
        end
        $finish;
    end

endmodule
